FILE: rtl/pfma_pkg.sv
package pfma_pkg;

    // Exponent scale k * 2^es + e, kept as one signed value
    typedef logic signed [13:0] t_exp;

    localparam logic [31:0] NAR_WORD  = 32'h8000_0000;
    localparam logic [31:0] ONE_WORD  = 32'h4000_0000;
    localparam logic [31:0] MAXP_WORD = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_ONE   = 32'hC000_0000;
    localparam logic [63:0] FRAC_MASK = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LOW_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;

    // Operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_NEG = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_IN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IN_EXP    = 2'd1;
    localparam logic [1:0] CFG_OUT_WIDTH = 2'd2;
    localparam logic [1:0] CFG_OUT_EXP   = 2'd3;

    // Bypass word for results settled early
    typedef struct packed {
        logic        hit;
        logic [31:0] val;
    } t_spec;

    typedef struct packed {
        logic [31:0]       frac;
        logic signed [6:0] k;
    } t_regime;

    // Decode -> multiply
    typedef struct packed {
        t_spec       spec;
        logic        sz;
        logic        sc;
        logic        czero;
        logic [31:0] ma;
        logic [31:0] mb;
        t_exp        rg;
        t_exp        ec;
        logic [29:0] fcw;
    } t_dec;

    // Product stage
    typedef struct packed {
        t_spec       spec;
        logic        sz;
        logic        sc;
        logic        czero;
        logic [63:0] prod;
        t_exp        rg;
        t_exp        ec;
        logic [29:0] fcw;
    } t_mul;

    // Aligned operands
    typedef struct packed {
        t_spec       spec;
        logic        sz;
        logic        sub;
        logic [63:0] big;
        logic [63:0] small_op;
        logic [5:0]  n;
        t_exp        ez;
    } t_aln;

    // Sum or normalized sum
    typedef struct packed {
        t_spec       spec;
        logic        sz;
        logic        more;
        logic [63:0] f;
        t_exp        ez;
    } t_sum;

    // Packed, before rounding
    typedef struct packed {
        t_spec       spec;
        logic        sz;
        logic        bnp;
        logic        more;
        logic [31:0] zb;
    } t_pck;

    // Leading zero count, 32 when the word is zero
    function automatic logic [5:0] lzc32(logic [31:0] x);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) n = 6'(31 - i);
        end
        return n;
    endfunction

    // Regime of a positive posit: bits after it, top-aligned, and k
    function automatic t_regime scan_regime(logic [31:0] v, logic [5:0] maxcnt);
        t_regime    r;
        logic [31:0] t0;
        logic [31:0] x;
        logic [5:0]  cnt;
        t0 = v << 2;
        x = v[30] ? ~t0 : t0;
        cnt = lzc32(x);
        if (cnt > maxcnt) cnt = maxcnt;
        r.frac = t0 << cnt;
        if (v[30]) begin
            r.k = {1'b0, cnt};
        end else begin
            r.k = ~{1'b0, cnt};
            r.frac[31] = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: rtl/pfma_decode.sv
module pfma_decode #(
    parameter int WORD_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [5:0]          i_in_width,
    input  logic [2:0]          i_in_es,
    input  logic [5:0]          i_out_width,
    input  logic [2:0]          i_out_es,
    input  logic [31:0]         i_mul_a,
    input  logic [31:0]         i_mul_b,
    input  logic [31:0]         i_addend,
    input  logic [1:0]          i_op,
    output logic                o_vld,
    output pfma_pkg::t_dec      o_dec
);

    logic                r_s1_vld;
    pfma_pkg::t_dec      r_s1;
    pfma_pkg::t_dec      n_s1;

    logic [31:0] mask_i, mask_o, a, b, c, a2, c2, aa, bb, cc, z2;
    logic [1:0]  opx;
    logic        bad, nar, pzero, sa, sb, sc, sz;
    pfma_pkg::t_regime ra, rb, rc;
    pfma_pkg::t_exp    ksum;
    logic [4:0]  fa, fb, fc5;
    logic [31:0] fcw;

    // Masking, special cases and sign handling
    always_comb begin
        mask_i = 32'hFFFF_FFFF << (6'd32 - i_in_width);
        mask_o = 32'hFFFF_FFFF << (6'd32 - i_out_width);
        a = i_mul_a & mask_i;
        b = i_mul_b & mask_i;
        c = i_addend & mask_o;
        opx = (i_op == pfma_pkg::OP_ADD || i_op == pfma_pkg::OP_SUB ||
               i_op == pfma_pkg::OP_NEG) ? i_op : pfma_pkg::OP_ADD;
        bad = (i_in_width < 6'd2) || (32'(i_in_width) > WORD_BITS) ||
              (i_out_width < 6'd2) || (32'(i_out_width) > WORD_BITS);
        nar = (a == pfma_pkg::NAR_WORD) || (b == pfma_pkg::NAR_WORD) ||
              (c == pfma_pkg::NAR_WORD);
        pzero = (a == 32'd0) || (b == 32'd0);
        a2 = (opx == pfma_pkg::OP_NEG) ? -a : a;
        c2 = (opx == pfma_pkg::OP_SUB) ? -c : c;
        sa = a2[31];
        sb = b[31];
        sc = c2[31];
        sz = sa ^ sb;
        aa = sa ? -a2 : a2;
        bb = sb ? -b : b;
        cc = sc ? -c2 : c2;
    end

    // Two-bit input format: product is 0 or 1, bitwise combine
    always_comb begin
        z2 = (aa[30] & bb[30]) ? pfma_pkg::ONE_WORD : 32'd0;
        if (sz) begin
            if (sc) z2 = (z2 | cc) ^ pfma_pkg::NAR_WORD;
            else if (cc == z2) z2 = 32'd0;
            else z2 = (z2 != 32'd0) ? pfma_pkg::NEG_ONE : pfma_pkg::ONE_WORD;
        end else begin
            if (sc) begin
                if (cc == z2) z2 = 32'd0;
                else z2 = (z2 != 32'd0) ? pfma_pkg::ONE_WORD : pfma_pkg::NEG_ONE;
            end else begin
                z2 = z2 | cc;
            end
        end
    end

    // Regime scans and exponent sums
    always_comb begin
        ra = pfma_pkg::scan_regime(aa, i_in_width - 6'd2);
        rb = pfma_pkg::scan_regime(bb, i_in_width - 6'd2);
        rc = pfma_pkg::scan_regime(cc, i_out_width - 6'd1);
        fa = 5'(ra.frac >> (5'd31 - 5'(i_in_es)));
        fb = 5'(rb.frac >> (5'd31 - 5'(i_in_es)));
        fc5 = 5'(rc.frac >> (5'd31 - 5'(i_out_es)));
        ksum = pfma_pkg::t_exp'(ra.k) + pfma_pkg::t_exp'(rb.k);
        fcw = (i_out_es == 3'd0) ? (rc.frac >> 1) : (rc.frac << (i_out_es - 3'd1));

        n_s1.sz = sz;
        n_s1.sc = sc;
        n_s1.czero = (cc == 32'd0);
        n_s1.ma = (ra.frac << i_in_es) | pfma_pkg::NAR_WORD;
        n_s1.mb = (rb.frac << i_in_es) | pfma_pkg::NAR_WORD;
        n_s1.rg = (ksum <<< i_in_es) + $signed({9'd0, fa}) + $signed({9'd0, fb});
        n_s1.ec = (pfma_pkg::t_exp'(rc.k) <<< i_out_es) + $signed({9'd0, fc5});
        n_s1.fcw = fcw[29:0];

        n_s1.spec.hit = 1'b1;
        if (bad || nar) n_s1.spec.val = pfma_pkg::NAR_WORD;
        else if (pzero) n_s1.spec.val = (opx == pfma_pkg::OP_SUB) ? -c : c;
        else if (i_in_width == 6'd2) n_s1.spec.val = z2;
        else begin
            n_s1.spec.hit = 1'b0;
            n_s1.spec.val = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_vld <= 1'b0;
        else r_s1_vld <= i_start;
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_vld = r_s1_vld;
    assign o_dec = r_s1;

endmodule

FILE: rtl/pfma_multiply.sv
module pfma_multiply (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  pfma_pkg::t_dec i_dec,
    output logic           o_vld,
    output pfma_pkg::t_aln o_aln
);

    logic           r_s2_vld, r_s3_vld;
    pfma_pkg::t_mul r_s2, n_s2;
    pfma_pkg::t_aln r_s3, n_s3;

    logic           carry, sub, swap;
    logic [63:0]    fz, fc;
    pfma_pkg::t_exp ep, sr, sr_abs;

    // Full product of the two significands
    always_comb begin
        n_s2.spec  = i_dec.spec;
        n_s2.sz    = i_dec.sz;
        n_s2.sc    = i_dec.sc;
        n_s2.czero = i_dec.czero;
        n_s2.prod  = 64'(i_dec.ma) * 64'(i_dec.mb);
        n_s2.rg    = i_dec.rg;
        n_s2.ec    = i_dec.ec;
        n_s2.fcw   = i_dec.fcw;
    end

    // Product normalize, exponent difference, operand order
    always_comb begin
        carry = r_s2.prod[63];
        fz = carry ? {1'b0, r_s2.prod[63:1]} : r_s2.prod;
        ep = r_s2.rg + (carry ? 14'sd1 : 14'sd0);
        fc = {2'b01, r_s2.fcw, 32'd0};
        sr = ep - r_s2.ec;
        sr_abs = sr[13] ? -sr : sr;
        sub = r_s2.sz ^ r_s2.sc;
        swap = sr[13] || ((sr == 14'sd0) && (fz < fc));

        n_s3.spec = r_s2.spec;
        if (r_s2.czero) begin
            n_s3.sz = r_s2.sz;
            n_s3.sub = 1'b0;
            n_s3.big = fz;
            n_s3.small_op = 64'd0;
            n_s3.n = 6'd0;
            n_s3.ez = ep;
        end else begin
            if (!r_s2.spec.hit && (sr == 14'sd0) && (fz == fc) && sub) begin
                n_s3.spec.hit = 1'b1;
                n_s3.spec.val = 32'd0;
            end
            n_s3.sz = (swap && sub) ? r_s2.sc : r_s2.sz;
            n_s3.sub = sub;
            n_s3.big = swap ? fc : fz;
            n_s3.small_op = swap ? fz : fc;
            n_s3.n = (sr_abs > 14'sd63) ? 6'd63 : sr_abs[5:0];
            n_s3.ez = sr[13] ? r_s2.ec : ep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s2_vld <= i_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
        r_s3 <= n_s3;
    end

    assign o_vld = r_s3_vld;
    assign o_aln = r_s3;

`ifndef SYNTH
    // larger operand always has its leading one at bit 62
    a_big_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_vld && !r_s3.spec.hit) |-> (r_s3.big[63:62] == 2'b01))
        else $error("aligned operand not normalized");
`endif

endmodule

FILE: rtl/pfma_align_add.sv
module pfma_align_add (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  pfma_pkg::t_aln i_aln,
    output logic           o_vld,
    output pfma_pkg::t_sum o_nrm
);

    logic           r_s4_vld, r_s5_vld;
    pfma_pkg::t_sum r_s4, n_s4, r_s5, n_s5;

    logic [63:0] sh, lowmask;
    logic        sticky;
    logic [5:0]  lz_hi, lz_lo, sl;
    logic [6:0]  lz;

    // Align the smaller operand, sticky, add or subtract
    always_comb begin
        sh = i_aln.small_op >> i_aln.n;
        lowmask = (64'd1 << i_aln.n) - 64'd1;
        sticky = |(i_aln.small_op & lowmask);
        n_s4.spec = i_aln.spec;
        n_s4.sz = i_aln.sz;
        n_s4.more = sticky;
        n_s4.ez = i_aln.ez;
        n_s4.f = i_aln.sub ? (i_aln.big - sh - 64'(sticky)) : (i_aln.big + sh);
    end

    // Renormalize to a leading one at bit 62
    always_comb begin
        lz_hi = pfma_pkg::lzc32(r_s4.f[63:32]);
        lz_lo = pfma_pkg::lzc32(r_s4.f[31:0]);
        lz = (lz_hi == 6'd32) ? (7'd32 + 7'(lz_lo)) : 7'(lz_hi);
        sl = 6'(lz - 7'd1);
        n_s5 = r_s4;
        if (r_s4.f[63]) begin
            n_s5.f = {1'b0, r_s4.f[63:1]};
            n_s5.ez = r_s4.ez + 14'sd1;
            n_s5.more = r_s4.more | r_s4.f[0];
        end else if (r_s4.f != 64'd0) begin
            n_s5.f = r_s4.f << sl;
            n_s5.ez = r_s4.ez - $signed({8'd0, sl});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else begin
            r_s4_vld <= i_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4 <= n_s4;
        r_s5 <= n_s5;
    end

    assign o_vld = r_s5_vld;
    assign o_nrm = r_s5;

`ifndef SYNTH
    // carry out of the sum is always folded back
    a_no_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s5_vld && !r_s5.spec.hit) |-> !r_s5.f[63])
        else $error("sum carry left after normalize");
`endif

endmodule

FILE: rtl/pfma_pack.sv
module pfma_pack (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  pfma_pkg::t_sum i_nrm,
    input  logic [5:0]     i_out_width,
    input  logic [2:0]     i_out_es,
    output logic           o_valid,
    output logic [31:0]    o_sum_out
);

    logic           r_s6_vld, r_out_vld;
    pfma_pkg::t_pck r_s6, n_s6;
    logic [31:0]    r_out, n_out;

    pfma_pkg::t_exp kz, regz, no_s, eso_s, s_t, d1_t;
    logic [4:0]  r5;
    logic [5:0]  s6, lsb;
    logic [1:0]  d1;
    logic [6:0]  fsh;
    logic [3:0]  mask4, ez;
    logic [31:0] topmask, regime, fracz, ezu, z, rnd;
    logic [63:0] fm;
    logic        sat, case_a, bnp, more_x;

    // Regime, exponent and fraction fields, round and sticky bits
    always_comb begin
        no_s = $signed({8'd0, i_out_width});
        eso_s = $signed({11'd0, i_out_es});
        lsb = 6'd32 - i_out_width;
        topmask = 32'hFFFF_FFFF << lsb;
        kz = i_nrm.ez >>> i_out_es;
        mask4 = 4'((5'd1 << i_out_es) - 5'd1);
        ez = i_nrm.ez[3:0] & mask4;
        regz = kz[13] ? -kz : (kz + 14'sd1);
        sat = regz > (no_s - 14'sd2);
        case_a = regz <= (no_s - eso_s - 14'sd2);
        r5 = regz[4:0];
        s_t = no_s - regz - eso_s;
        s6 = s_t[5:0];
        d1_t = regz - no_s + eso_s + 14'sd1;
        d1 = d1_t[1:0];
        fm = i_nrm.f & pfma_pkg::FRAC_MASK;
        regime = kz[13] ? (pfma_pkg::ONE_WORD >> r5)
                        : (pfma_pkg::MAXP_WORD - (pfma_pkg::MAXP_WORD >> r5));
        fsh = 7'({2'd0, r5} + {4'd0, i_out_es} + 7'd32);

        if (case_a) begin
            fracz = 32'(fm >> fsh) & topmask;
            bnp = fm[6'd63 - s6];
            more_x = |(fm & (pfma_pkg::LOW_MASK >> s6));
            ezu = {28'd0, ez} << (5'd30 - 5'(i_out_es) - r5);
        end else begin
            fracz = 32'd0;
            bnp = ez[d1];
            more_x = (|(ez & 4'((5'd1 << d1) - 5'd1))) | (|fm);
            ezu = ({28'd0, ez} >> (3'(d1) + 3'd1)) << lsb;
        end

        n_s6.spec = i_nrm.spec;
        n_s6.sz = i_nrm.sz;
        if (sat) begin
            n_s6.zb = kz[13] ? (32'd1 << lsb) : (pfma_pkg::MAXP_WORD & topmask);
            n_s6.bnp = 1'b0;
            n_s6.more = i_nrm.more;
        end else begin
            n_s6.zb = regime + ezu + fracz;
            n_s6.bnp = bnp;
            n_s6.more = i_nrm.more | more_x;
        end
    end

    // Round to nearest even, apply sign, pick bypass word
    always_comb begin
        rnd = ((32'((r_s6.zb >> lsb) & 32'd1)) | 32'(r_s6.more)) << lsb;
        z = r_s6.bnp ? (r_s6.zb + rnd) : r_s6.zb;
        if (r_s6.spec.hit) n_out = r_s6.spec.val;
        else n_out = r_s6.sz ? -z : z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s6_vld <= i_vld;
            r_out_vld <= r_s6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6 <= n_s6;
        r_out <= n_out;
    end

    assign o_valid = r_out_vld;
    assign o_sum_out = r_out;

endmodule

FILE: rtl/posit_fused_multiply_add_mixed_top.sv
// Posit fused multiply-add, mixed precision: sum = a*b +/- c or -a*b + c,
// rounded once to the output format (nearest, ties to even). Fully pipelined,
// seven register stages (decode, 32x32 multiply, align, add, normalize, pack,
// round): one word is taken every cycle, its result strobes on o_valid from the
// round register. busy never rises and the receiver cannot stall, so results
// must be taken in the cycle they appear. Widths and exponent sizes are to be
// written through the cfg port only while no word is in flight, a rule for the
// user that the block does not enforce; there is no clearing pass after reset.
module posit_fused_multiply_add_mixed_top #(
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data,
    input  logic [31:0] i_mul_a,
    input  logic [31:0] i_mul_b,
    input  logic [31:0] i_addend,
    input  logic [1:0]  i_op,
    output logic        o_valid,
    output logic [31:0] o_sum_out
);

    logic [5:0] r_in_width, r_out_width;
    logic [2:0] r_in_exp, r_out_exp;
    logic [2:0] in_es, out_es;

    logic           dec_vld, aln_vld, nrm_vld;
    pfma_pkg::t_dec dec;
    pfma_pkg::t_aln aln;
    pfma_pkg::t_sum nrm;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width <= 6'd16;
            r_in_exp <= 3'd1;
            r_out_width <= 6'd16;
            r_out_exp <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pfma_pkg::CFG_IN_WIDTH:  r_in_width <= i_cfg_data;
                pfma_pkg::CFG_IN_EXP:    r_in_exp <= i_cfg_data[2:0];
                pfma_pkg::CFG_OUT_WIDTH: r_out_width <= i_cfg_data;
                pfma_pkg::CFG_OUT_EXP:   r_out_exp <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Exponent sizes above four act as four
    assign in_es = (r_in_exp > 3'd4) ? 3'd4 : r_in_exp;
    assign out_es = (r_out_exp > 3'd4) ? 3'd4 : r_out_exp;

    assign busy = 1'b0;

    pfma_decode #(.WORD_BITS(WORD_BITS)) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start && !busy),
        .i_in_width  (r_in_width),
        .i_in_es     (in_es),
        .i_out_width (r_out_width),
        .i_out_es    (out_es),
        .i_mul_a     (i_mul_a),
        .i_mul_b     (i_mul_b),
        .i_addend    (i_addend),
        .i_op        (i_op),
        .o_vld       (dec_vld),
        .o_dec       (dec)
    );

    pfma_multiply u_multiply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (dec_vld),
        .i_dec   (dec),
        .o_vld   (aln_vld),
        .o_aln   (aln)
    );

    pfma_align_add u_align_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (aln_vld),
        .i_aln   (aln),
        .o_vld   (nrm_vld),
        .o_nrm   (nrm)
    );

    pfma_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (nrm_vld),
        .i_nrm       (nrm),
        .i_out_width (r_out_width),
        .i_out_es    (out_es),
        .o_valid     (o_valid),
        .o_sum_out   (o_sum_out)
    );

`ifndef SYNTH
    // every result word comes from a matching earlier start
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 7))
        else $error("result without matching start");
`endif

endmodule
